[hdl/lmtc_pkg.sv]
// ----------------------------------------------------------------------------
// LCD mode timing package
// Widths, timing constants, mode and register codes, shared structs and the
// status source latch function of the scanline timing controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lmtc_pkg;

  localparam int unsigned DOT_W  = 10;
  localparam int unsigned EDGE_W = 9;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned DOTS_W = 8;
  localparam int unsigned ENA_W  = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Timing in dot cycles
  localparam int unsigned LINE_DOTS     = 456;
  localparam int unsigned OAM_DOTS      = 80;
  localparam int unsigned XFER_DOTS     = 172;
  localparam int unsigned XFER_END_DOTS = OAM_DOTS + XFER_DOTS;
  localparam int unsigned VBLANK_LINE   = 144;
  localparam int unsigned WRAP_LINE     = 154;
  localparam int unsigned DOT_MAX       = (1 << DOT_W) - 1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

  // Status enable bit positions
  localparam int unsigned SRC_HBLANK = 0;
  localparam int unsigned SRC_VBLANK = 1;
  localparam int unsigned SRC_OAM    = 2;
  localparam int unsigned SRC_MATCH  = 3;

  // Input actions
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_LCD_OFF = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LCD_ON       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_LINE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAT_ENABLES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STAT_QUIRK   = 2'd3;

  typedef struct packed {
    logic [DOT_W-1:0]  dot_count;
    logic [EDGE_W-1:0] next_edge;
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] line;
    logic              stat_latch;
    logic              match_flag;
  } lmtc_state_t;

  localparam lmtc_state_t STATE_RESET = '{
    dot_count:  '0,
    next_edge:  EDGE_W'(LINE_DOTS),
    mode:       MODE_VBLANK,
    line:       '0,
    stat_latch: 1'b0,
    match_flag: 1'b0
  };

  typedef struct packed {
    logic              lcd_on;
    logic [LINE_W-1:0] compare_line;
    logic [ENA_W-1:0]  stat_enables;
    logic              stat_quirk;
  } lmtc_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              render_valid;
    logic [LINE_W-1:0] render_line;
  } lmtc_result_t;

  typedef struct packed {
    logic pulse;
    logic latch;
  } lmtc_src_t;

  // Rising-edge latch of a status source: pulse once while enabled.
  function automatic lmtc_src_t src_check(input logic enabled, input logic latch);
    lmtc_src_t r;
    r.pulse = enabled & ~latch;
    r.latch = enabled;
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/lmtc_step.sv]
// ----------------------------------------------------------------------------
// LCD mode timing step
// Next timing state and result of one request: dot accumulation, one mode
// step, line advance, coincidence, interrupt pulses and the LCD-off reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtc_step (
  input  wire lmtc_pkg::lmtc_state_t             state_i,
  input  wire lmtc_pkg::lmtc_cfg_t               cfg_i,
  input  wire logic                              action_i,
  input  wire logic [lmtc_pkg::DOTS_W-1:0]       dots_i,
  output lmtc_pkg::lmtc_state_t                  state_o,
  output lmtc_pkg::lmtc_result_t                 result_o
);

  logic [lmtc_pkg::DOT_W:0]    dot_sum;
  logic [lmtc_pkg::DOT_W-1:0]  dot_sat;
  logic [lmtc_pkg::DOT_W-1:0]  dot_wrap;
  logic [lmtc_pkg::LINE_W-1:0] line_inc;
  logic                        edge_hit;
  logic                        ena_hblank;
  logic                        ena_vblank;
  logic                        ena_oam;
  logic                        match_inc;
  logic                        match_zero;
  lmtc_pkg::lmtc_src_t         src_hb;
  lmtc_pkg::lmtc_src_t         src_vb;
  lmtc_pkg::lmtc_src_t         src_oam;
  logic                        pulse;
  logic                        vb_pulse;
  logic                        rv;
  logic [lmtc_pkg::LINE_W-1:0] rl;

  assign dot_sum  = {1'b0, state_i.dot_count} + (lmtc_pkg::DOT_W + 1)'(dots_i);
  // saturate instead of wrapping
  assign dot_sat  = (dot_sum > (lmtc_pkg::DOT_W + 1)'(lmtc_pkg::DOT_MAX))
                    ? lmtc_pkg::DOT_W'(lmtc_pkg::DOT_MAX) : dot_sum[lmtc_pkg::DOT_W-1:0];
  assign dot_wrap = (dot_sat >= lmtc_pkg::DOT_W'(lmtc_pkg::LINE_DOTS))
                    ? dot_sat - lmtc_pkg::DOT_W'(lmtc_pkg::LINE_DOTS) : '0;
  assign edge_hit = dot_sat >= lmtc_pkg::DOT_W'(state_i.next_edge);
  assign line_inc = state_i.line + 1'b1;

  assign ena_hblank = cfg_i.stat_quirk | cfg_i.stat_enables[lmtc_pkg::SRC_HBLANK];
  assign ena_vblank = cfg_i.stat_quirk | cfg_i.stat_enables[lmtc_pkg::SRC_VBLANK];
  assign ena_oam    = cfg_i.stat_quirk | cfg_i.stat_enables[lmtc_pkg::SRC_OAM];

  assign src_hb  = lmtc_pkg::src_check(ena_hblank, state_i.stat_latch);
  assign src_vb  = lmtc_pkg::src_check(ena_vblank, state_i.stat_latch);
  assign src_oam = lmtc_pkg::src_check(ena_oam, state_i.stat_latch);

  assign match_inc  = line_inc == cfg_i.compare_line;
  assign match_zero = cfg_i.compare_line == '0;

  always_comb begin
    state_o  = state_i;
    pulse    = 1'b0;
    vb_pulse = 1'b0;
    rv       = 1'b0;
    rl       = '0;
    if (action_i == lmtc_pkg::ACT_LCD_OFF) begin
      state_o.line       = '0;
      state_o.dot_count  = '0;
      pulse              = src_hb.pulse;
      state_o.stat_latch = src_hb.latch;
      state_o.mode       = lmtc_pkg::MODE_HBLANK;
      state_o.next_edge  = lmtc_pkg::EDGE_W'(lmtc_pkg::LINE_DOTS);
    end else if (cfg_i.lcd_on) begin
      state_o.dot_count = dot_sat;
      if (edge_hit) begin
        unique case (state_i.mode)
          lmtc_pkg::MODE_OAM: begin
            state_o.mode      = lmtc_pkg::MODE_XFER;
            state_o.next_edge = state_i.next_edge + lmtc_pkg::EDGE_W'(lmtc_pkg::XFER_DOTS);
          end
          lmtc_pkg::MODE_XFER: begin
            pulse              = src_hb.pulse;
            state_o.stat_latch = src_hb.latch;
            state_o.mode       = lmtc_pkg::MODE_HBLANK;
            state_o.next_edge  = lmtc_pkg::EDGE_W'(lmtc_pkg::LINE_DOTS);
          end
          lmtc_pkg::MODE_HBLANK: begin
            state_o.dot_count  = dot_wrap;
            rv                 = 1'b1;
            rl                 = state_i.line;
            state_o.line       = line_inc;
            state_o.match_flag = match_inc;
            if (line_inc == lmtc_pkg::LINE_W'(lmtc_pkg::VBLANK_LINE)) begin
              vb_pulse           = 1'b1;
              pulse              = src_vb.pulse;
              state_o.stat_latch = src_vb.latch;
              state_o.mode       = lmtc_pkg::MODE_VBLANK;
              state_o.next_edge  = lmtc_pkg::EDGE_W'(lmtc_pkg::LINE_DOTS);
            end else begin
              pulse              = src_oam.pulse;
              state_o.stat_latch = src_oam.latch;
              state_o.mode       = lmtc_pkg::MODE_OAM;
              state_o.next_edge  = lmtc_pkg::EDGE_W'(lmtc_pkg::OAM_DOTS);
            end
            pulse = pulse | (match_inc & cfg_i.stat_enables[lmtc_pkg::SRC_MATCH]);
          end
          lmtc_pkg::MODE_VBLANK: begin
            state_o.dot_count  = dot_wrap;
            state_o.line       = line_inc;
            state_o.match_flag = match_inc;
            pulse              = match_inc & cfg_i.stat_enables[lmtc_pkg::SRC_MATCH];
            // wrap to line 0: coincidence checked again for the new line
            if (line_inc >= lmtc_pkg::LINE_W'(lmtc_pkg::WRAP_LINE)) begin
              state_o.line       = '0;
              state_o.stat_latch = src_oam.latch;
              state_o.mode       = lmtc_pkg::MODE_OAM;
              state_o.next_edge  = lmtc_pkg::EDGE_W'(lmtc_pkg::OAM_DOTS);
              state_o.match_flag = match_zero;
              pulse = pulse | src_oam.pulse
                    | (match_zero & cfg_i.stat_enables[lmtc_pkg::SRC_MATCH]);
            end
          end
          default: begin
            state_o = state_i;
          end
        endcase
      end
    end
  end

  always_comb begin
    result_o.mode         = state_o.mode;
    result_o.line         = state_o.line;
    result_o.coincidence  = state_o.match_flag;
    result_o.vblank_irq   = vb_pulse;
    result_o.stat_irq     = pulse;
    result_o.render_valid = rv;
    result_o.render_line  = rl;
  end

endmodule

`default_nettype wire

[hdl/lcd_mode_timing_controller_unit.sv]
// ----------------------------------------------------------------------------
// LCD mode timing controller
// Scanline timing of a handheld LCD: mode sequencing, line counting,
// coincidence flag, interrupt pulses and render line flags.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i/in_ready_o, action, dots   | request in
//  out     | out_valid_o/out_ready_i, mode .. line | result out
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i     | write only
//
// One request per cycle sustained while out_ready_i is high; a request passes
// through the input register, then the result register.
// The timing state advances in the cycle a request moves into the result
// register, so back-to-back requests see each other's updates.
// Reset: lcd on, compare line 0, enables 0, vblank at line 0, edge 456.
// While out_ready_i is low the result holds and one more request is buffered.
`default_nettype none

module lcd_mode_timing_controller_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              action_i,
  input  wire logic [lmtc_pkg::DOTS_W-1:0]       dots_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [lmtc_pkg::MODE_W-1:0]            mode_o,
  output logic [lmtc_pkg::LINE_W-1:0]            line_o,
  output logic                                   coincidence_o,
  output logic                                   vblank_irq_o,
  output logic                                   stat_irq_o,
  output logic                                   render_valid_o,
  output logic [lmtc_pkg::LINE_W-1:0]            render_line_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lmtc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lmtc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  lmtc_pkg::lmtc_cfg_t    cfg_q;
  lmtc_pkg::lmtc_state_t  state_q;
  lmtc_pkg::lmtc_state_t  state_d;
  lmtc_pkg::lmtc_result_t res_d;
  lmtc_pkg::lmtc_result_t res_q;

  logic                        in_valid_q;
  logic                        action_q;
  logic [lmtc_pkg::DOTS_W-1:0] dots_q;
  logic                        out_valid_q;
  logic                        advance;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lcd_on       <= 1'b1;
      cfg_q.compare_line <= '0;
      cfg_q.stat_enables <= '0;
      cfg_q.stat_quirk   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lmtc_pkg::CFG_LCD_ON:       cfg_q.lcd_on       <= cfg_data_i[0];
        lmtc_pkg::CFG_COMPARE_LINE: cfg_q.compare_line <= cfg_data_i[lmtc_pkg::LINE_W-1:0];
        lmtc_pkg::CFG_STAT_ENABLES: cfg_q.stat_enables <= cfg_data_i[lmtc_pkg::ENA_W-1:0];
        lmtc_pkg::CFG_STAT_QUIRK:   cfg_q.stat_quirk   <= cfg_data_i[0];
        default:                    cfg_q              <= cfg_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      dots_q   <= dots_i;
    end
  end

  lmtc_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .action_i (action_q),
    .dots_i   (dots_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // timing state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmtc_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mode_o         = res_q.mode;
  assign line_o         = res_q.line;
  assign coincidence_o  = res_q.coincidence;
  assign vblank_irq_o   = res_q.vblank_irq;
  assign stat_irq_o     = res_q.stat_irq;
  assign render_valid_o = res_q.render_valid;
  assign render_line_o  = res_q.render_line;

  // line stays inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line < lmtc_pkg::LINE_W'(lmtc_pkg::WRAP_LINE))
    else $error("line counter beyond frame");

  // deadline matches the mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == lmtc_pkg::MODE_OAM
       && state_q.next_edge == lmtc_pkg::EDGE_W'(lmtc_pkg::OAM_DOTS))
    || (state_q.mode == lmtc_pkg::MODE_XFER
       && state_q.next_edge == lmtc_pkg::EDGE_W'(lmtc_pkg::XFER_END_DOTS))
    || ((state_q.mode == lmtc_pkg::MODE_HBLANK || state_q.mode == lmtc_pkg::MODE_VBLANK)
       && state_q.next_edge == lmtc_pkg::EDGE_W'(lmtc_pkg::LINE_DOTS)))
    else $error("mode deadline mismatch");

  // render line is zero without a render flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.render_valid) |-> res_q.render_line == '0)
    else $error("render line set without render flag");

  // vblank pulse only on entry to line 144 in vblank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.vblank_irq) |->
      (res_q.mode == lmtc_pkg::MODE_VBLANK
       && res_q.line == lmtc_pkg::LINE_W'(lmtc_pkg::VBLANK_LINE)))
    else $error("vblank pulse outside vblank entry");

endmodule

`default_nettype wire
